// ===== src/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation block.
`default_nettype none
package bpc_pkg;

    localparam int RawW    = 20;   // raw conversion width
    localparam int CoefW   = 16;   // calibration word width
    localparam int CfgW    = 48;   // packed calibration register width
    localparam int IdxW    = 2;    // calibration register index width
    localparam int DivW    = 64;   // dividend / quotient width
    localparam int DvsW    = 31;   // divisor magnitude width
    localparam int TfW     = 25;   // working width of the fine temperature
    localparam int OutW    = 32;   // pressure and fine temperature width

    // Calibration register indexes
    localparam logic [IdxW-1:0] CfgTemp   = 2'd0;
    localparam logic [IdxW-1:0] CfgPressA = 2'd1;
    localparam logic [IdxW-1:0] CfgPressB = 2'd2;
    localparam logic [IdxW-1:0] CfgPressC = 2'd3;

    // Polynomial constants
    localparam logic signed [TfW:0] TfineOffset = 26'sd128000;
    localparam logic [RawW:0]       PressBase   = 21'd1048576;
    localparam logic [63:0]         XOffset     = 64'h0000_8000_0000_0000;
    localparam logic [63:0]         NumScale    = 64'd3125;

    // Calibration words unpacked from the four registers
    typedef struct packed {
        logic        [CoefW-1:0] t1;
        logic signed [CoefW-1:0] t2;
        logic signed [CoefW-1:0] t3;
        logic        [CoefW-1:0] p1;
        logic signed [CoefW-1:0] p2;
        logic signed [CoefW-1:0] p3;
        logic signed [CoefW-1:0] p4;
        logic signed [CoefW-1:0] p5;
        logic signed [CoefW-1:0] p6;
        logic signed [CoefW-1:0] p7;
        logic signed [CoefW-1:0] p8;
        logic signed [CoefW-1:0] p9;
    } t_coefs;

    // Data carried alongside the divider
    typedef struct packed {
        logic signed [OutW-1:0] tfine;
        logic                   neg;
        logic                   zero;
    } t_side;

endpackage
`default_nettype wire

// ===== src/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation block.
// Takes one raw temperature / raw pressure pair per item and returns the fine
// temperature and the compensated pressure (unsigned Q24.8 pascals); a zero
// divisor gives pressure 0 with o_divide_error set. One item is accepted every
// cycle unless o_stall is high; items pass the 11-stage polynomial front end,
// the 64-stage divider (one quotient bit per stage) and the 6-stage correction
// back end. The whole pipeline holds while a finished item waits under
// i_stall. Calibration registers reset to zero; the user must write them
// through the plain write port only while the block is idle (not enforced).
`default_nettype none
module barometric_pressure_compensation (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpc_pkg::IdxW-1:0]      i_cfg_idx,
    input  wire logic [bpc_pkg::CfgW-1:0]      i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [bpc_pkg::RawW-1:0]      i_raw_pressure,
    input  wire logic [bpc_pkg::RawW-1:0]      i_raw_temperature,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [bpc_pkg::OutW-1:0]           o_pressure_q8,
    output logic signed [bpc_pkg::OutW-1:0]    o_fine_temperature,
    output logic                               o_divide_error
);
    import bpc_pkg::*;

    logic [CfgW-1:0] r_temp_coefs;
    logic [CfgW-1:0] r_press_coefs_a;
    logic [CfgW-1:0] r_press_coefs_b;
    logic [CfgW-1:0] r_press_coefs_c;

    t_coefs          w_coefs;
    logic            w_en;
    logic            w_f_vld;
    logic [DivW-1:0] w_f_num;
    logic [DvsW-1:0] w_f_dvs;
    t_side           w_f_side;
    logic            w_d_vld;
    logic [DivW-1:0] w_d_q;
    t_side           w_d_side;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coefs    <= '0;
            r_press_coefs_a <= '0;
            r_press_coefs_b <= '0;
            r_press_coefs_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgTemp:   r_temp_coefs    <= i_cfg_data;
                CfgPressA: r_press_coefs_a <= i_cfg_data;
                CfgPressB: r_press_coefs_b <= i_cfg_data;
                CfgPressC: r_press_coefs_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack calibration words
    assign w_coefs.t1 = r_temp_coefs[15:0];
    assign w_coefs.t2 = r_temp_coefs[31:16];
    assign w_coefs.t3 = r_temp_coefs[47:32];
    assign w_coefs.p1 = r_press_coefs_a[15:0];
    assign w_coefs.p2 = r_press_coefs_a[31:16];
    assign w_coefs.p3 = r_press_coefs_a[47:32];
    assign w_coefs.p4 = r_press_coefs_b[15:0];
    assign w_coefs.p5 = r_press_coefs_b[31:16];
    assign w_coefs.p6 = r_press_coefs_b[47:32];
    assign w_coefs.p7 = r_press_coefs_c[15:0];
    assign w_coefs.p8 = r_press_coefs_c[31:16];
    assign w_coefs.p9 = r_press_coefs_c[47:32];

    // pipeline advances unless a finished item is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    bpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (i_valid),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_coefs           (w_coefs),
        .o_valid           (w_f_vld),
        .o_num             (w_f_num),
        .o_dvs             (w_f_dvs),
        .o_side            (w_f_side)
    );

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_num   (w_f_num),
        .i_dvs   (w_f_dvs),
        .i_side  (w_f_side),
        .o_valid (w_d_vld),
        .o_q     (w_d_q),
        .o_side  (w_d_side)
    );

    bpc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (w_en),
        .i_valid            (w_d_vld),
        .i_q                (w_d_q),
        .i_side             (w_d_side),
        .i_coefs            (w_coefs),
        .o_valid            (o_valid),
        .o_pressure_q8      (o_pressure_q8),
        .o_fine_temperature (o_fine_temperature),
        .o_divide_error     (o_divide_error)
    );

endmodule
`default_nettype wire

// ===== src/bpc_front.sv =====
// Front pipeline: fine temperature and pressure divisor / dividend.
`default_nettype none
module bpc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [bpc_pkg::RawW-1:0]      i_raw_pressure,
    input  wire logic [bpc_pkg::RawW-1:0]      i_raw_temperature,
    input  wire bpc_pkg::t_coefs               i_coefs,
    output logic                               o_valid,
    output logic [bpc_pkg::DivW-1:0]           o_num,
    output logic [bpc_pkg::DvsW-1:0]           o_dvs,
    output bpc_pkg::t_side                     o_side
);
    import bpc_pkg::*;

    logic [10:0] r_vld;

    // stage 1
    logic signed [17:0]   r1_d1;
    logic signed [16:0]   r1_d2;
    logic [RawW-1:0]      r1_adcp;
    // stage 2
    logic signed [33:0]   r2_m1;
    logic signed [33:0]   r2_sq;
    logic [RawW-1:0]      r2_adcp;
    // stage 3
    logic signed [37:0]   r3_m2;
    logic signed [22:0]   r3_ta;
    logic [RawW-1:0]      r3_adcp;
    // stage 4
    logic signed [TfW-1:0] r4_tf;
    logic [RawW-1:0]      r4_adcp;
    // stage 5
    logic signed [51:0]   r5_aa;
    logic signed [41:0]   r5_ap5;
    logic signed [41:0]   r5_ap2;
    logic signed [TfW-1:0] r5_tf;
    logic [RawW-1:0]      r5_adcp;
    // stage 6
    logic [63:0]          r6_aap6;
    logic [63:0]          r6_aap3;
    logic signed [41:0]   r6_ap5;
    logic signed [41:0]   r6_ap2;
    logic signed [TfW-1:0] r6_tf;
    logic [RawW-1:0]      r6_adcp;
    // stage 7
    logic [63:0]          r7_a;
    logic [63:0]          r7_b;
    logic signed [TfW-1:0] r7_tf;
    logic [RawW-1:0]      r7_adcp;
    // stage 8
    logic [63:0]          r8_x;
    logic [63:0]          r8_num0;
    logic signed [TfW-1:0] r8_tf;
    // stage 9
    logic [47:0]          r9_xlo;
    logic [31:0]          r9_xhi;
    logic [63:0]          r9_num;
    logic signed [TfW-1:0] r9_tf;
    // stage 10
    logic [63:0]          r10_prod;
    logic [63:0]          r10_num;
    logic signed [TfW-1:0] r10_tf;
    // stage 11
    logic [DivW-1:0]      r11_num;
    logic [DvsW-1:0]      r11_dvs;
    t_side                r11_side;

    logic signed [17:0]   n_d1;
    logic signed [16:0]   n_d2;
    logic signed [21:0]   w_sq12;
    logic signed [TfW:0]  w_ap;
    logic signed [67:0]   w_aap6;
    logic signed [67:0]   w_aap3;
    logic [RawW:0]        w_p21;
    logic [47:0]          w_xhi;
    logic [DvsW-1:0]      w_dvs;

    assign n_d1   = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, i_coefs.t1, 1'b0});
    assign n_d2   = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, i_coefs.t1});
    assign w_sq12 = r2_sq[33:12];
    assign w_ap   = {r4_tf[TfW-1], r4_tf} - TfineOffset;
    assign w_aap6 = r5_aa * i_coefs.p6;
    assign w_aap3 = r5_aa * i_coefs.p3;
    assign w_p21  = PressBase - {1'b0, r7_adcp};
    assign w_xhi  = r8_x[63:32] * i_coefs.p1;
    assign w_dvs  = r10_prod[63:33];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[9:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // temperature differences
            r1_d1   <= n_d1;
            r1_d2   <= n_d2;
            r1_adcp <= i_raw_pressure;
            // first products
            r2_m1   <= r1_d1 * i_coefs.t2;
            r2_sq   <= r1_d2 * r1_d2;
            r2_adcp <= r1_adcp;
            // second temperature product
            r3_m2   <= w_sq12 * i_coefs.t3;
            r3_ta   <= r2_m1[33:11];
            r3_adcp <= r2_adcp;
            // fine temperature
            r4_tf   <= $signed({{2{r3_ta[22]}}, r3_ta}) + $signed({r3_m2[37], r3_m2[37:14]});
            r4_adcp <= r3_adcp;
            // offset temperature products
            r5_aa   <= w_ap * w_ap;
            r5_ap5  <= w_ap * i_coefs.p5;
            r5_ap2  <= w_ap * i_coefs.p2;
            r5_tf   <= r4_tf;
            r5_adcp <= r4_adcp;
            // square times coefficients, wrapping at 64 bits
            r6_aap6 <= w_aap6[63:0];
            r6_aap3 <= w_aap3[63:0];
            r6_ap5  <= r5_ap5;
            r6_ap2  <= r5_ap2;
            r6_tf   <= r5_tf;
            r6_adcp <= r5_adcp;
            // polynomial sums
            r7_b    <= r6_aap6 + ({{22{r6_ap5[41]}}, r6_ap5} << 17)
                     + ({{48{i_coefs.p4[15]}}, i_coefs.p4} << 35);
            r7_a    <= {{8{r6_aap3[63]}}, r6_aap3[63:8]}
                     + ({{22{r6_ap2[41]}}, r6_ap2} << 12);
            r7_tf   <= r6_tf;
            r7_adcp <= r6_adcp;
            // divisor base and dividend base
            r8_x    <= r7_a + XOffset;
            r8_num0 <= ({43'd0, w_p21} << 31) - r7_b;
            r8_tf   <= r7_tf;
            // divisor partial products, dividend scale
            r9_xlo  <= r8_x[31:0] * i_coefs.p1;
            r9_xhi  <= w_xhi[31:0];
            r9_num  <= r8_num0 * NumScale;
            r9_tf   <= r8_tf;
            // divisor product
            r10_prod <= {16'd0, r9_xlo} + {r9_xhi, 32'd0};
            r10_num  <= r9_num;
            r10_tf   <= r9_tf;
            // magnitudes and sign for the divider
            r11_num  <= r10_num[63] ? (64'd0 - r10_num) : r10_num;
            r11_dvs  <= w_dvs[DvsW-1] ? (31'd0 - w_dvs) : w_dvs;
            r11_side.neg   <= r10_num[63] ^ w_dvs[DvsW-1];
            r11_side.zero  <= (w_dvs == '0);
            r11_side.tfine <= {{(OutW-TfW){r10_tf[TfW-1]}}, r10_tf};
        end
    end

    assign o_valid = r_vld[10];
    assign o_num   = r11_num;
    assign o_dvs   = r11_dvs;
    assign o_side  = r11_side;

endmodule
`default_nettype wire

// ===== src/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module bpc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [bpc_pkg::DivW-1:0]  i_num,
    input  wire logic [bpc_pkg::DvsW-1:0]  i_dvs,
    input  wire bpc_pkg::t_side            i_side,
    output logic                           o_valid,
    output logic [bpc_pkg::DivW-1:0]       o_q,
    output bpc_pkg::t_side                 o_side
);
    import bpc_pkg::*;

    logic [DivW-1:0] w_q    [0:DivW-1];
    logic [DvsW-1:0] w_rem  [0:DivW-1];
    logic [DvsW-1:0] w_dvs  [0:DivW-1];
    t_side           w_side [0:DivW-1];

    logic [DivW-1:0] r_q    [1:DivW];
    logic [DvsW-1:0] r_rem  [1:DivW];
    logic [DvsW-1:0] r_dvs  [1:DivW];
    t_side           r_side [1:DivW];
    logic [DivW:1]   r_vld;

    assign w_q[0]    = i_num;
    assign w_rem[0]  = '0;
    assign w_dvs[0]  = i_dvs;
    assign w_side[0] = i_side;

    // valid bits follow the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivW-1:1], i_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < DivW; k++) begin : g_stage
            logic [DvsW:0] w_trial;
            logic          w_ge;

            // shift in the next dividend bit and try a subtract
            assign w_trial = {w_rem[k], w_q[k][DivW-1]};
            assign w_ge    = (w_trial >= {1'b0, w_dvs[k]});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1]  <= w_ge ? DvsW'(w_trial - {1'b0, w_dvs[k]}) : w_trial[DvsW-1:0];
                    r_q[k+1]    <= {w_q[k][DivW-2:0], w_ge};
                    r_dvs[k+1]  <= w_dvs[k];
                    r_side[k+1] <= w_side[k];
                end
            end

            if (k > 0) begin : g_link
                assign w_q[k]    = r_q[k];
                assign w_rem[k]  = r_rem[k];
                assign w_dvs[k]  = r_dvs[k];
                assign w_side[k] = r_side[k];
            end
        end
    endgenerate

    assign o_valid = r_vld[DivW];
    assign o_q     = r_q[DivW];
    assign o_side  = r_side[DivW];

endmodule
`default_nettype wire

// ===== src/bpc_back.sv =====
// Back pipeline: quotient sign, second-order correction and output register.
`default_nettype none
module bpc_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [bpc_pkg::DivW-1:0]  i_q,
    input  wire bpc_pkg::t_side            i_side,
    input  wire bpc_pkg::t_coefs           i_coefs,
    output logic                           o_valid,
    output logic [bpc_pkg::OutW-1:0]       o_pressure_q8,
    output logic signed [bpc_pkg::OutW-1:0] o_fine_temperature,
    output logic                           o_divide_error
);
    import bpc_pkg::*;

    logic [5:0] r_vld;

    logic [63:0]        r1_p;
    t_side              r1_side;

    logic [63:0]        r2_p;
    logic [63:0]        r2_s;
    logic [63:0]        r2_m;
    logic signed [48:0] r2_plo;
    logic [31:0]        r2_phi;
    t_side              r2_side;

    logic [63:0]        r3_p;
    logic [63:0]        r3_ll;
    logic [31:0]        r3_lh;
    logic [31:0]        r3_hl;
    logic [63:0]        r3_b2;
    t_side              r3_side;

    logic [63:0]        r4_p;
    logic [63:0]        r4_ms;
    logic [63:0]        r4_b2;
    t_side              r4_side;

    logic [63:0]        r5_sum;
    t_side              r5_side;

    logic [OutW-1:0]        r6_press;
    logic signed [OutW-1:0] r6_tf;
    logic                   r6_err;

    logic signed [50:0] w_s;
    logic signed [66:0] w_ms1;
    logic signed [48:0] w_phi;
    logic [63:0]        w_lh;
    logic [63:0]        w_hl;
    logic [31:0]        w_p7;

    assign w_s   = r1_p[63:13];
    assign w_ms1 = w_s * i_coefs.p9;
    assign w_phi = $signed({1'b0, r1_p[63:32]}) * i_coefs.p8;
    assign w_lh  = r2_m[63:32] * r2_s[31:0];
    assign w_hl  = r2_m[31:0] * r2_s[63:32];
    assign w_p7  = {{12{i_coefs.p7[15]}}, i_coefs.p7, 4'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // restore the quotient sign
            r1_p    <= i_side.neg ? (64'd0 - i_q) : i_q;
            r1_side <= i_side;
            // first correction products
            r2_p    <= r1_p;
            r2_s    <= {{13{w_s[50]}}, w_s};
            r2_m    <= w_ms1[63:0];
            r2_plo  <= $signed({1'b0, r1_p[31:0]}) * i_coefs.p8;
            r2_phi  <= w_phi[31:0];
            r2_side <= r1_side;
            // partial products of the square term
            r3_p    <= r2_p;
            r3_ll   <= r2_m[31:0] * r2_s[31:0];
            r3_lh   <= w_lh[31:0];
            r3_hl   <= w_hl[31:0];
            r3_b2   <= {{15{r2_plo[48]}}, r2_plo} + {r2_phi, 32'd0};
            r3_side <= r2_side;
            // square term
            r4_p    <= r3_p;
            r4_ms   <= r3_ll + {r3_lh + r3_hl, 32'd0};
            r4_b2   <= r3_b2;
            r4_side <= r3_side;
            // corrected pressure
            r5_sum  <= r4_p + {{25{r4_ms[63]}}, r4_ms[63:25]}
                     + {{19{r4_b2[63]}}, r4_b2[63:19]};
            r5_side <= r4_side;
            // output register
            r6_press <= r5_side.zero ? '0 : (r5_sum[39:8] + w_p7);
            r6_tf    <= r5_side.tfine;
            r6_err   <= r5_side.zero;
        end
    end

    assign o_valid            = r_vld[5];
    assign o_pressure_q8      = r6_press;
    assign o_fine_temperature = r6_tf;
    assign o_divide_error     = r6_err;

endmodule
`default_nettype wire

// ===== dv/barometric_pressure_checker.sv =====
// Checker for the barometric pressure compensation block: predicts and compares results.
`timescale 1ns / 1ps
module barometric_pressure_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bpc_pkg::IdxW-1:0]   i_cfg_idx,
    input  wire logic [bpc_pkg::CfgW-1:0]   i_cfg_data,
    input  wire logic                       i_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [bpc_pkg::RawW-1:0]   i_raw_pressure,
    input  wire logic [bpc_pkg::RawW-1:0]   i_raw_temperature,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [bpc_pkg::OutW-1:0]   i_pressure_q8,
    input  wire logic [bpc_pkg::OutW-1:0]   i_fine_temperature,
    input  wire logic                       i_divide_error,
    output int                              o_fail_count,
    output int                              o_pending
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [31:0] press;
        logic [31:0] tfine;
        logic        err;
    } t_reading;

    logic [CfgW-1:0] cal_temp, cal_pa, cal_pb, cal_pc;
    t_reading        readings_due[$];

    function automatic logic signed [63:0] cal_word(input logic [CfgW-1:0] r, input int k,
                                                    input bit sgn);
        logic [15:0] w;
        w = r[16*k +: 16];
        return sgn ? 64'(signed'(w)) : {48'd0, w};
    endfunction

    // 64-bit integer compensation polynomial
    function automatic t_reading compensate(input logic [19:0] adc_p,
                                            input logic [19:0] adc_t);
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] d, a, b, tf, p, num;
        logic [63:0] an, ad, q;
        t_reading r;
        t1 = cal_word(cal_temp, 0, 0); t2 = cal_word(cal_temp, 1, 1);
        t3 = cal_word(cal_temp, 2, 1);
        p1 = cal_word(cal_pa, 0, 0); p2 = cal_word(cal_pa, 1, 1); p3 = cal_word(cal_pa, 2, 1);
        p4 = cal_word(cal_pb, 0, 1); p5 = cal_word(cal_pb, 1, 1); p6 = cal_word(cal_pb, 2, 1);
        p7 = cal_word(cal_pc, 0, 1); p8 = cal_word(cal_pc, 1, 1); p9 = cal_word(cal_pc, 2, 1);
        d  = $signed({44'd0, adc_t >> 3}) - (t1 <<< 1);
        a  = (d * t2) >>> 11;
        d  = $signed({44'd0, adc_t >> 4}) - t1;
        b  = (((d * d) >>> 12) * t3) >>> 14;
        tf = a + b;
        r.tfine = tf[31:0];
        r.press = '0;
        r.err   = 1'b0;
        a = tf - 64'sd128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
        if (a == 0) begin
            r.err = 1'b1;
        end else begin
            p   = 64'sd1048576 - $signed({44'd0, adc_p});
            num = ((p <<< 31) - b) * 64'sd3125;
            an  = num[63] ? -num : num;
            ad  = a[63] ? -a : a;
            q   = an / ad;
            p   = (num[63] ^ a[63]) ? -q : q;
            a   = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            b   = (p8 * p) >>> 19;
            p   = ((p + a + b) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    assign o_pending = readings_due.size();

    // Calibration shadow, predictions on input, comparison on output
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            cal_temp <= '0; cal_pa <= '0; cal_pb <= '0; cal_pc <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgTemp:   cal_temp <= i_cfg_data;
                    CfgPressA: cal_pa   <= i_cfg_data;
                    CfgPressB: cal_pb   <= i_cfg_data;
                    CfgPressC: cal_pc   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                readings_due.push_back(compensate(i_raw_pressure, i_raw_temperature));
            if (i_out_valid && !i_out_stall) begin
                if (readings_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: p=%h tf=%h e=%b",
                                 i_pressure_q8, i_fine_temperature, i_divide_error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = readings_due.pop_front();
                    if (want.press !== i_pressure_q8 || want.tfine !== i_fine_temperature
                        || want.err !== i_divide_error) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp p=%h tf=%h e=%b got p=%h tf=%h e=%b",
                                     want.press, want.tfine, want.err, i_pressure_q8,
                                     i_fine_temperature, i_divide_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/barometric_pressure_compensation_test.sv =====
// Stimulus and verdict for the barometric pressure compensation block.
`timescale 1ns / 1ps
module barometric_pressure_compensation_test;
    import bpc_pkg::*;

    localparam int Latency = 81;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IdxW-1:0]   cfg_idx = CfgTemp;
    logic [CfgW-1:0]   cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [RawW-1:0]   raw_p = '0, raw_t = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OutW-1:0]   press_q8, tfine;
    logic              div_err;
    int                fail_count, pending;
    bit                quiet = 1'b0;
    bit                hold_off = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    barometric_pressure_compensation dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall),
        .i_raw_pressure(raw_p), .i_raw_temperature(raw_t), .o_valid(out_valid),
        .i_stall(out_stall), .o_pressure_q8(press_q8), .o_fine_temperature(tfine),
        .o_divide_error(div_err)
    );

    barometric_pressure_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_raw_pressure(raw_p), .i_raw_temperature(raw_t), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_pressure_q8(press_q8), .i_fine_temperature(tfine),
        .i_divide_error(div_err), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls: random bursts, one long hold-off, none when quiet
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // One register write, then a cycle with the write enable low
    task automatic write_cal(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one reading pair and wait until it is taken
    task automatic send_reading(input logic [19:0] p, input logic [19:0] t, input bit gaps);
        if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_p    <= p;
        raw_t    <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_readings();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (Latency + 10) @(posedge clk);
    endtask

    // Realistic calibration with some random spread
    function automatic logic [15:0] jit(input int base, input int span);
        return 16'(base + $urandom_range(0, 2 * span) - span);
    endfunction

    task automatic load_typical();
        write_cal(CfgTemp,   {jit(-1000, 300), jit(26000, 500), jit(27500, 1000)});
        write_cal(CfgPressA, {jit(6000, 100), jit(-10600, 200), jit(36500, 1000)});
        write_cal(CfgPressB, {jit(-7000, 200), jit(140, 30), jit(2850, 100)});
        write_cal(CfgPressC, {jit(6000, 100), jit(-14600, 200), jit(15500, 100)});
    endtask

    task automatic load_random();
        write_cal(CfgTemp,   48'({$urandom, $urandom}));
        write_cal(CfgPressA, 48'({$urandom, $urandom}));
        write_cal(CfgPressB, 48'({$urandom, $urandom}));
        write_cal(CfgPressC, 48'({$urandom, $urandom}));
    endtask

    initial begin
        int ph, k;
        logic [19:0] rp, rt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: zero divisor on every item
        send_reading(20'd0, 20'd0, 0);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        drain_readings();

        // Directed: typical calibration, field extremes
        load_typical();
        send_reading(20'd0, 20'd0, 0);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        send_reading(20'd0, 20'hFFFFF, 0);
        send_reading(20'hFFFFF, 20'd0, 0);
        send_reading(20'd415148, 20'd519888, 0);
        send_reading(20'h55555, 20'hAAAAA, 0);
        send_reading(20'hAAAAA, 20'h55555, 0);
        drain_readings();

        // Extreme calibrations: all ones, sign corners
        write_cal(CfgTemp,   48'hFFFF_FFFF_FFFF);
        write_cal(CfgPressA, 48'hFFFF_FFFF_FFFF);
        write_cal(CfgPressB, 48'hFFFF_FFFF_FFFF);
        write_cal(CfgPressC, 48'hFFFF_FFFF_FFFF);
        send_reading(20'd0, 20'hFFFFF, 0);
        send_reading(20'hFFFFF, 20'd0, 0);
        drain_readings();
        write_cal(CfgTemp,   48'h8000_7FFF_FFFF);
        write_cal(CfgPressA, 48'h8000_7FFF_FFFF);
        write_cal(CfgPressB, 48'h7FFF_8000_7FFF);
        write_cal(CfgPressC, 48'h8000_7FFF_8000);
        send_reading(20'd0, 20'd0, 0);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        send_reading(20'h80000, 20'h7FFFF, 0);
        drain_readings();
        // P1 zero with live temperature: divisor zero, fine temperature valid
        load_typical();
        write_cal(CfgPressA, 48'h1234_5678_0000);
        send_reading(20'd300000, 20'd500000, 0);
        drain_readings();

        // Random phases: mostly realistic calibration, some fully random
        for (ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) load_random(); else load_typical();
            if (ph == 6) quiet = 1'b1;
            for (k = 0; k < 150; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    rp = 20'($urandom_range(200000, 700000));
                    rt = 20'($urandom_range(350000, 650000));
                end else begin
                    rp = 20'($urandom);
                    rt = 20'($urandom);
                end
                if (ph == 1 && k == 10) hold_off = 1'b1;
                send_reading(rp, rt, 1);
            end
            // sender pause until every result is back
            drain_readings();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
